[rtl/core/tcm_pkg.sv]
// Shared constants, types and codes for the touch calibrate and map unit.
`default_nettype none

package tcm_pkg;

    localparam int ADC_BITS       = 10;
    localparam int EDGE_MARGIN    = 50;
    localparam int GAIN_FRAC_BITS = 16;

    localparam int RAW_W      = 10;
    localparam int RES_W      = 12;
    localparam int SC_W       = RES_W - 1;
    localparam int OUT_W      = 14;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = 3;
    localparam int NUM_POINTS = 5;
    localparam int REG_IDX_W  = 1;
    localparam int GAIN_W     = 32;

    localparam int DIFF_W      = RAW_W + 1;
    localparam int SPAN_W      = RAW_W + 2;
    localparam int LCD_W       = RES_W + 1;
    localparam int DIVIDEND_W  = RES_W + GAIN_FRAC_BITS + 1;
    localparam int DIVISOR_W   = SPAN_W;
    localparam int PROD_W      = GAIN_W + RAW_W;
    localparam int SCALED_W    = PROD_W - GAIN_FRAC_BITS;
    localparam int MAP_W       = ((SCALED_W > RES_W) ? SCALED_W : RES_W) + 2;
    localparam int GAIN_WIDE_W = ((DIVIDEND_W > GAIN_W) ? DIVIDEND_W : GAIN_W) + 1;
    localparam int MUL_CNT_W   = $clog2(RAW_W + 1);
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

    localparam logic [RAW_W-1:0] ADC_MASK = RAW_W'((64'd1 << ADC_BITS) - 64'd1);
    localparam logic [LCD_W-1:0] LCD_MARGIN = LCD_W'(2 * EDGE_MARGIN);
    localparam logic [RES_W-1:0] WIDTH_RESET = RES_W'(480);
    localparam logic [RES_W-1:0] HEIGHT_RESET = RES_W'(272);
    localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(64'd1 << GAIN_FRAC_BITS);
    localparam logic signed [MAP_W-1:0] MAP_HI = MAP_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic signed [MAP_W-1:0] MAP_LO = ~MAP_HI;
    localparam logic signed [GAIN_WIDE_W-1:0] GAIN_HI =
        GAIN_WIDE_W'((64'd1 << (GAIN_W - 1)) - 64'd1);
    localparam logic signed [GAIN_WIDE_W-1:0] GAIN_LO = ~GAIN_HI;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_X_GO,
        ST_MAP_X,
        ST_MAP_Y_GO,
        ST_MAP_Y,
        ST_CAL_PREP,
        ST_DIV_X_GO,
        ST_DIV_X,
        ST_DIV_Y_GO,
        ST_DIV_Y,
        ST_CAL_COMMIT,
        ST_POST
    } tcm_state_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_MAPPED,
        STATUS_STORED,
        STATUS_CAL_DONE,
        STATUS_CAL_FAIL
    } tcm_status_t;

    typedef enum logic {
        KIND_POINT,
        KIND_SAMPLE
    } tcm_kind_t;

    typedef enum logic [IDX_W-1:0] {
        POINT_A,
        POINT_B,
        POINT_C,
        POINT_D,
        POINT_E
    } tcm_point_idx_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SCREEN_WIDTH,
        REG_SCREEN_HEIGHT
    } tcm_reg_t;

    typedef struct packed {
        logic [RAW_W-1:0] x;
        logic [RAW_W-1:0] y;
    } tcm_point_t;

endpackage

`default_nettype wire

[rtl/core/tcm_if.sv]
// Valid/ready channel interfaces for touch items and mapped results.
`default_nettype none

interface tcm_touch_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [tcm_pkg::IDX_W-1:0]    point_index;
    logic [tcm_pkg::RAW_W-1:0]    raw_x;
    logic [tcm_pkg::RAW_W-1:0]    raw_y;

    modport source (output valid, output kind, output point_index, output raw_x,
                    output raw_y, input ready);
    modport sink (input valid, input kind, input point_index, input raw_x,
                  input raw_y, output ready);
endinterface

interface tcm_result_if;
    logic                             valid;
    logic                             ready;
    logic [tcm_pkg::STATUS_W-1:0]     status;
    logic signed [tcm_pkg::OUT_W-1:0] screen_x;
    logic signed [tcm_pkg::OUT_W-1:0] screen_y;

    modport source (output valid, output status, output screen_x, output screen_y,
                    input ready);
    modport sink (input valid, input status, input screen_x, input screen_y,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/tcm_serial_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module tcm_serial_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tcm_pkg::GAIN_W-1:0]    mcand,
    input  wire logic [tcm_pkg::RAW_W-1:0]     mplier,
    output logic                               done,
    output logic [tcm_pkg::PROD_W-1:0]         product
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [tcm_pkg::MUL_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [tcm_pkg::GAIN_W-1:0]       mcand_reg;
    logic [tcm_pkg::GAIN_W-1:0]       acc_hi_reg;
    logic [tcm_pkg::RAW_W-1:0]        lo_reg;
    logic [tcm_pkg::GAIN_W:0]         sum;
    logic                             last_step;

    assign last_step = (cnt_reg == tcm_pkg::MUL_CNT_W'(tcm_pkg::RAW_W - 1));
    assign sum = {1'b0, acc_hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + tcm_pkg::MUL_CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= mcand;
            acc_hi_reg <= '0;
            lo_reg     <= mplier;
        end
        else if (busy_reg)
        begin
            acc_hi_reg <= sum[tcm_pkg::GAIN_W:1];
            lo_reg     <= {sum[0], lo_reg[tcm_pkg::RAW_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {acc_hi_reg, lo_reg};

endmodule

`default_nettype wire

[rtl/core/tcm_serial_div.sv]
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module tcm_serial_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [tcm_pkg::DIVIDEND_W-1:0]    dividend,
    input  wire logic [tcm_pkg::DIVISOR_W-1:0]     divisor,
    output logic                                   done,
    output logic [tcm_pkg::DIVIDEND_W-1:0]         quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [tcm_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [tcm_pkg::DIVISOR_W-1:0]     divisor_reg;
    logic [tcm_pkg::DIVISOR_W-1:0]     rem_reg;
    logic [tcm_pkg::DIVIDEND_W-1:0]    work_reg;
    logic [tcm_pkg::DIVISOR_W:0]       trial;
    logic [tcm_pkg::DIVISOR_W:0]       trial_sub;
    logic                              fits;
    logic                              last_step;

    assign last_step = (cnt_reg == tcm_pkg::DIV_CNT_W'(tcm_pkg::DIVIDEND_W - 1));
    assign trial     = {rem_reg, work_reg[tcm_pkg::DIVIDEND_W-1]};
    assign fits      = (trial >= {1'b0, divisor_reg});
    assign trial_sub = trial - {1'b0, divisor_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + tcm_pkg::DIV_CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // The partial remainder stays below the divisor, so one bit of headroom suffices.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            rem_reg     <= '0;
            work_reg    <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial_sub[tcm_pkg::DIVISOR_W-1:0]
                             : trial[tcm_pkg::DIVISOR_W-1:0];
            work_reg <= {work_reg[tcm_pkg::DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

`default_nettype wire

[rtl/core/touch_calibrate_and_map_unit.sv]
// Top level: five-point touch calibration and raw-to-screen mapping.
//
// Channel   Direction  Contents                              Handshake
// touch     in         kind, point_index, raw_x, raw_y       valid / ready
// result    out        status, screen_x, screen_y            valid / ready
// wr_*      in         wr_index, wr_data                     wr_en, no wait
//
// A sample is mapped by two RAW_W-step passes through the one bit-serial
// multiplier, one pass per axis.
// Point E runs two DIVIDEND_W-step passes through the one restoring divider
// unless a span sum is zero; other points go straight to the output stage.
// Reset restores unity gains, zero centres and the default resolution.
// One finished transaction waits in the output register while the next is
// accepted; the block holds its final step until that register drains.
`default_nettype none

module touch_calibrate_and_map_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    tcm_touch_if.sink                              touch,
    tcm_result_if.source                           result,
    input  wire logic                              wr_en,
    input  wire logic [tcm_pkg::REG_IDX_W-1:0]     wr_index,
    input  wire logic [tcm_pkg::RES_W-1:0]         wr_data
);

    function automatic logic signed [tcm_pkg::DIFF_W-1:0] raw_diff(
        input logic [tcm_pkg::RAW_W-1:0] a,
        input logic [tcm_pkg::RAW_W-1:0] b
    );
        raw_diff = {1'b0, a} - {1'b0, b};
    endfunction

    function automatic logic [tcm_pkg::DIFF_W-1:0] diff_mag(
        input logic signed [tcm_pkg::DIFF_W-1:0] d
    );
        diff_mag = d[tcm_pkg::DIFF_W-1] ? tcm_pkg::DIFF_W'(-d) : tcm_pkg::DIFF_W'(d);
    endfunction

    function automatic logic signed [tcm_pkg::SPAN_W-1:0] span_sum(
        input logic signed [tcm_pkg::DIFF_W-1:0] a,
        input logic signed [tcm_pkg::DIFF_W-1:0] b
    );
        span_sum = {a[tcm_pkg::DIFF_W-1], a} + {b[tcm_pkg::DIFF_W-1], b};
    endfunction

    tcm_pkg::tcm_state_t state_reg, state_next;

    logic in_ready;
    logic accept;
    logic mul_start;
    logic div_start;
    logic commit;
    logic post_load;
    logic span_zero;

    logic out_valid_reg, out_valid_next;
    tcm_pkg::tcm_status_t             out_status_reg;
    logic signed [tcm_pkg::OUT_W-1:0] out_x_reg;
    logic signed [tcm_pkg::OUT_W-1:0] out_y_reg;

    logic [tcm_pkg::RES_W-1:0]         width_reg;
    logic [tcm_pkg::RES_W-1:0]         height_reg;
    logic                              axes_swapped_reg;
    logic signed [tcm_pkg::GAIN_W-1:0] gain_x_reg;
    logic signed [tcm_pkg::GAIN_W-1:0] gain_y_reg;
    tcm_pkg::tcm_point_t               tc_reg;
    logic [tcm_pkg::SC_W-1:0]          sc_x_reg;
    logic [tcm_pkg::SC_W-1:0]          sc_y_reg;

    tcm_pkg::tcm_point_t               points_reg [tcm_pkg::NUM_POINTS];
    tcm_pkg::tcm_point_t               samp_reg;
    logic                              swap_reg;
    logic signed [tcm_pkg::SPAN_W-1:0] span_x_reg;
    logic signed [tcm_pkg::SPAN_W-1:0] span_y_reg;
    logic                              map_neg_reg;
    logic                              div_neg_reg;
    logic signed [tcm_pkg::GAIN_W-1:0] gain_x_new_reg;
    logic signed [tcm_pkg::GAIN_W-1:0] gain_y_new_reg;
    tcm_pkg::tcm_status_t              res_status_reg;
    logic signed [tcm_pkg::OUT_W-1:0]  res_x_reg;
    logic signed [tcm_pkg::OUT_W-1:0]  res_y_reg;

    logic [tcm_pkg::RAW_W-1:0] in_x;
    logic [tcm_pkg::RAW_W-1:0] in_y;

    // Calibration preparation.
    tcm_pkg::tcm_point_t               pa, pb, pc, pd, pe;
    logic signed [tcm_pkg::DIFF_W-1:0] dx_ba, dy_ba, dx_cd, dy_cd, dx_da, dy_da;
    logic signed [tcm_pkg::DIFF_W-1:0] dx_cb, dy_cb;
    logic                              swap_calc;
    logic signed [tcm_pkg::SPAN_W-1:0] span_x_calc;
    logic signed [tcm_pkg::SPAN_W-1:0] span_y_calc;

    // Mapping datapath.
    logic                              map_axis_y;
    logic [tcm_pkg::RAW_W-1:0]         map_raw;
    logic [tcm_pkg::RAW_W-1:0]         map_tc;
    logic signed [tcm_pkg::DIFF_W-1:0] map_diff;
    logic [tcm_pkg::DIFF_W-1:0]        map_diff_abs;
    logic signed [tcm_pkg::GAIN_W-1:0] map_gain;
    logic [tcm_pkg::GAIN_W-1:0]        map_gain_mag;
    logic [tcm_pkg::SC_W-1:0]          map_sc;
    logic [tcm_pkg::PROD_W-1:0]        mul_product;
    logic                              mul_done;
    logic signed [tcm_pkg::MAP_W-1:0]  map_sc_ext;
    logic signed [tcm_pkg::MAP_W-1:0]  map_scaled_ext;
    logic signed [tcm_pkg::MAP_W-1:0]  map_sum;
    logic signed [tcm_pkg::OUT_W-1:0]  map_sat;

    // Gain division datapath.
    logic                                   div_axis_y;
    logic [tcm_pkg::RES_W-1:0]              div_res;
    logic signed [tcm_pkg::LCD_W-1:0]       div_lcd;
    logic [tcm_pkg::LCD_W-1:0]              div_lcd_abs;
    logic [tcm_pkg::DIVIDEND_W-1:0]         div_dividend;
    logic signed [tcm_pkg::SPAN_W-1:0]      div_span;
    logic [tcm_pkg::DIVISOR_W-1:0]          div_divisor;
    logic [tcm_pkg::DIVIDEND_W-1:0]         div_quotient;
    logic                                   div_done;
    logic signed [tcm_pkg::GAIN_WIDE_W-1:0] gain_wide;
    logic signed [tcm_pkg::GAIN_W-1:0]      gain_sat;

    assign in_x = touch.raw_x & tcm_pkg::ADC_MASK;
    assign in_y = touch.raw_y & tcm_pkg::ADC_MASK;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (touch.kind == tcm_pkg::KIND_SAMPLE)
                        state_next = tcm_pkg::ST_MAP_X_GO;
                    else if (touch.point_index == tcm_pkg::POINT_E)
                        state_next = tcm_pkg::ST_CAL_PREP;
                    else
                        state_next = tcm_pkg::ST_POST;
                end
            end
            tcm_pkg::ST_MAP_X_GO:   state_next = tcm_pkg::ST_MAP_X;
            tcm_pkg::ST_MAP_X:
            begin
                if (mul_done)
                    state_next = tcm_pkg::ST_MAP_Y_GO;
            end
            tcm_pkg::ST_MAP_Y_GO:   state_next = tcm_pkg::ST_MAP_Y;
            tcm_pkg::ST_MAP_Y:
            begin
                if (mul_done)
                    state_next = tcm_pkg::ST_POST;
            end
            tcm_pkg::ST_CAL_PREP:   state_next = tcm_pkg::ST_DIV_X_GO;
            tcm_pkg::ST_DIV_X_GO:
            begin
                if (span_zero)
                    state_next = tcm_pkg::ST_POST;
                else
                    state_next = tcm_pkg::ST_DIV_X;
            end
            tcm_pkg::ST_DIV_X:
            begin
                if (div_done)
                    state_next = tcm_pkg::ST_DIV_Y_GO;
            end
            tcm_pkg::ST_DIV_Y_GO:   state_next = tcm_pkg::ST_DIV_Y;
            tcm_pkg::ST_DIV_Y:
            begin
                if (div_done)
                    state_next = tcm_pkg::ST_CAL_COMMIT;
            end
            tcm_pkg::ST_CAL_COMMIT: state_next = tcm_pkg::ST_POST;
            tcm_pkg::ST_POST:
            begin
                if (post_load)
                    state_next = tcm_pkg::ST_IDLE;
            end
            default:                state_next = tcm_pkg::ST_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        in_ready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        commit    = 1'b0;
        post_load = 1'b0;
        case (state_reg)
            tcm_pkg::ST_IDLE:       in_ready = 1'b1;
            tcm_pkg::ST_MAP_X_GO:   mul_start = 1'b1;
            tcm_pkg::ST_MAP_Y_GO:   mul_start = 1'b1;
            tcm_pkg::ST_DIV_X_GO:   div_start = !span_zero;
            tcm_pkg::ST_DIV_Y_GO:   div_start = 1'b1;
            tcm_pkg::ST_CAL_COMMIT: commit = 1'b1;
            tcm_pkg::ST_POST:       post_load = !out_valid_reg || result.ready;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = touch.valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (post_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    // Axis swap and span sums from the stored corner points.
    always_comb
    begin
        pa = points_reg[tcm_pkg::POINT_A];
        pb = points_reg[tcm_pkg::POINT_B];
        pc = points_reg[tcm_pkg::POINT_C];
        pd = points_reg[tcm_pkg::POINT_D];
        pe = points_reg[tcm_pkg::POINT_E];
        dx_ba = raw_diff(pb.x, pa.x);
        dy_ba = raw_diff(pb.y, pa.y);
        dx_cd = raw_diff(pc.x, pd.x);
        dy_cd = raw_diff(pc.y, pd.y);
        dx_da = raw_diff(pd.x, pa.x);
        dy_da = raw_diff(pd.y, pa.y);
        dx_cb = raw_diff(pc.x, pb.x);
        dy_cb = raw_diff(pc.y, pb.y);
        swap_calc = !(diff_mag(dx_ba) > diff_mag(dy_ba));
        if (swap_calc)
        begin
            span_x_calc = span_sum(dy_ba, dy_cd);
            span_y_calc = span_sum(dx_da, dx_cb);
        end
        else
        begin
            span_x_calc = span_sum(dx_ba, dx_cd);
            span_y_calc = span_sum(dy_da, dy_cb);
        end
    end

    // Mapping: operands for the multiplier and the truncated, saturated result.
    always_comb
    begin
        map_axis_y   = (state_reg == tcm_pkg::ST_MAP_Y_GO) || (state_reg == tcm_pkg::ST_MAP_Y);
        map_raw      = map_axis_y ? samp_reg.y : samp_reg.x;
        map_tc       = map_axis_y ? tc_reg.y : tc_reg.x;
        map_diff     = raw_diff(map_raw, map_tc);
        map_diff_abs = diff_mag(map_diff);
        map_gain     = map_axis_y ? gain_y_reg : gain_x_reg;
        map_gain_mag = map_gain[tcm_pkg::GAIN_W-1] ? tcm_pkg::GAIN_W'(-map_gain)
                                                   : tcm_pkg::GAIN_W'(map_gain);
        map_sc       = map_axis_y ? sc_y_reg : sc_x_reg;
        map_sc_ext     = tcm_pkg::MAP_W'(map_sc);
        map_scaled_ext = tcm_pkg::MAP_W'(mul_product[tcm_pkg::PROD_W-1:tcm_pkg::GAIN_FRAC_BITS]);
        map_sum      = map_neg_reg ? (map_sc_ext - map_scaled_ext)
                                   : (map_sc_ext + map_scaled_ext);
        if (map_sum > tcm_pkg::MAP_HI)
            map_sat = tcm_pkg::OUT_W'(tcm_pkg::MAP_HI);
        else if (map_sum < tcm_pkg::MAP_LO)
            map_sat = tcm_pkg::OUT_W'(tcm_pkg::MAP_LO);
        else
            map_sat = map_sum[tcm_pkg::OUT_W-1:0];
    end

    // Gain: 2*(res - 2*margin) scaled by the fraction bits, over the span sum.
    always_comb
    begin
        div_axis_y   = (state_reg == tcm_pkg::ST_DIV_Y_GO) || (state_reg == tcm_pkg::ST_DIV_Y);
        div_res      = div_axis_y ? height_reg : width_reg;
        div_lcd      = {1'b0, div_res} - tcm_pkg::LCD_MARGIN;
        div_lcd_abs  = div_lcd[tcm_pkg::LCD_W-1] ? tcm_pkg::LCD_W'(-div_lcd)
                                                 : tcm_pkg::LCD_W'(div_lcd);
        div_dividend = {div_lcd_abs[tcm_pkg::RES_W-1:0],
                        {(tcm_pkg::GAIN_FRAC_BITS + 1){1'b0}}};
        div_span     = div_axis_y ? span_y_reg : span_x_reg;
        div_divisor  = div_span[tcm_pkg::SPAN_W-1] ? tcm_pkg::DIVISOR_W'(-div_span)
                                                   : tcm_pkg::DIVISOR_W'(div_span);
        span_zero    = (span_x_reg == '0) || (span_y_reg == '0);
        gain_wide    = div_neg_reg ? -tcm_pkg::GAIN_WIDE_W'(div_quotient)
                                   : tcm_pkg::GAIN_WIDE_W'(div_quotient);
        if (gain_wide > tcm_pkg::GAIN_HI)
            gain_sat = tcm_pkg::GAIN_W'(tcm_pkg::GAIN_HI);
        else if (gain_wide < tcm_pkg::GAIN_LO)
            gain_sat = tcm_pkg::GAIN_W'(tcm_pkg::GAIN_LO);
        else
            gain_sat = gain_wide[tcm_pkg::GAIN_W-1:0];
    end

    tcm_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (map_gain_mag),
        .mplier  (map_diff_abs[tcm_pkg::RAW_W-1:0]),
        .done    (mul_done),
        .product (mul_product)
    );

    tcm_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tcm_pkg::ST_IDLE;
            out_valid_reg    <= 1'b0;
            width_reg        <= tcm_pkg::WIDTH_RESET;
            height_reg       <= tcm_pkg::HEIGHT_RESET;
            axes_swapped_reg <= 1'b0;
            gain_x_reg       <= tcm_pkg::GAIN_ONE;
            gain_y_reg       <= tcm_pkg::GAIN_ONE;
            tc_reg           <= '0;
            sc_x_reg         <= '0;
            sc_y_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                case (wr_index)
                    tcm_pkg::REG_SCREEN_WIDTH:  width_reg <= wr_data;
                    tcm_pkg::REG_SCREEN_HEIGHT: height_reg <= wr_data;
                    default:
                    begin
                        width_reg <= width_reg;
                    end
                endcase
            end
            if (commit)
            begin
                axes_swapped_reg <= swap_reg;
                gain_x_reg       <= gain_x_new_reg;
                gain_y_reg       <= gain_y_new_reg;
                tc_reg           <= swap_reg ? tcm_pkg::tcm_point_t'{x: pe.y, y: pe.x} : pe;
                sc_x_reg         <= width_reg[tcm_pkg::RES_W-1:1];
                sc_y_reg         <= height_reg[tcm_pkg::RES_W-1:1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (touch.kind == tcm_pkg::KIND_SAMPLE)
            begin
                samp_reg       <= axes_swapped_reg ? tcm_pkg::tcm_point_t'{x: in_y, y: in_x}
                                                   : tcm_pkg::tcm_point_t'{x: in_x, y: in_y};
                res_status_reg <= tcm_pkg::STATUS_MAPPED;
            end
            else
            begin
                if (touch.point_index < tcm_pkg::IDX_W'(tcm_pkg::NUM_POINTS))
                    points_reg[touch.point_index] <= '{x: in_x, y: in_y};
                res_status_reg <= tcm_pkg::STATUS_STORED;
                res_x_reg      <= '0;
                res_y_reg      <= '0;
            end
        end
        if (state_reg == tcm_pkg::ST_CAL_PREP)
        begin
            swap_reg   <= swap_calc;
            span_x_reg <= span_x_calc;
            span_y_reg <= span_y_calc;
        end
        if (mul_start)
            map_neg_reg <= map_diff[tcm_pkg::DIFF_W-1] ^ map_gain[tcm_pkg::GAIN_W-1];
        if (div_start)
            div_neg_reg <= div_lcd[tcm_pkg::LCD_W-1] ^ div_span[tcm_pkg::SPAN_W-1];
        if ((state_reg == tcm_pkg::ST_DIV_X_GO) && span_zero)
            res_status_reg <= tcm_pkg::STATUS_CAL_FAIL;
        if (mul_done && (state_reg == tcm_pkg::ST_MAP_X))
            res_x_reg <= map_sat;
        if (mul_done && (state_reg == tcm_pkg::ST_MAP_Y))
            res_y_reg <= map_sat;
        if (div_done && (state_reg == tcm_pkg::ST_DIV_X))
            gain_x_new_reg <= gain_sat;
        if (div_done && (state_reg == tcm_pkg::ST_DIV_Y))
            gain_y_new_reg <= gain_sat;
        if (commit)
            res_status_reg <= tcm_pkg::STATUS_CAL_DONE;
        if (post_load)
        begin
            out_status_reg <= res_status_reg;
            out_x_reg      <= res_x_reg;
            out_y_reg      <= res_y_reg;
        end
    end

    assign touch.ready     = in_ready;
    assign result.valid    = out_valid_reg;
    assign result.status   = out_status_reg;
    assign result.screen_x = out_x_reg;
    assign result.screen_y = out_y_reg;

endmodule

`default_nettype wire

[rtl/core/tcm_checker.sv]
// Port-level checks for the touch calibrate and map unit, bound to the top level.
`default_nettype none

module tcm_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             touch_valid,
    input wire logic                             touch_ready,
    input wire logic                             result_valid,
    input wire logic                             result_ready,
    input wire logic [tcm_pkg::STATUS_W-1:0]     status,
    input wire logic signed [tcm_pkg::OUT_W-1:0] screen_x,
    input wire logic signed [tcm_pkg::OUT_W-1:0] screen_y
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(status) && $stable(screen_x) && $stable(screen_y))
    else $error("result transaction changed while stalled");

    // Calibration transactions always report zero coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != tcm_pkg::STATUS_MAPPED) |->
            (screen_x == '0) && (screen_y == '0))
    else $error("calibration result carries nonzero coordinates");

    // The unit works on one transaction at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        touch_valid && touch_ready |=> !touch_ready)
    else $error("input accepted while previous transaction in progress");

    // A new result is only posted while the input side is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !$past(result_valid && !result_ready) |-> !$past(touch_ready))
    else $error("result posted without a transaction in progress");

endmodule

bind touch_calibrate_and_map_unit tcm_checker u_tcm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .touch_valid  (touch.valid),
    .touch_ready  (touch.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (result.status),
    .screen_x     (result.screen_x),
    .screen_y     (result.screen_y)
);

`default_nettype wire

[dv/touch_calibrate_and_map_unit_tb.sv]
// Self-checking testbench for the touch calibrate and map unit.
`default_nettype none

module touch_calibrate_and_map_unit_tb;

    typedef struct {
        tcm_pkg::tcm_status_t              status;
        logic signed [tcm_pkg::OUT_W-1:0]  sx;
        logic signed [tcm_pkg::OUT_W-1:0]  sy;
    } screen_report_t;

    localparam int QUIET_LIMIT = 3000;
    localparam int ITEMS_PER_PHASE = 320;
    localparam longint OUT_MAX = (longint'(1) << (tcm_pkg::OUT_W - 1)) - 1;
    localparam longint OUT_MIN = -(longint'(1) << (tcm_pkg::OUT_W - 1));
    localparam logic [tcm_pkg::IDX_W-1:0] FIRST_BAD_IDX =
        tcm_pkg::IDX_W'(tcm_pkg::NUM_POINTS);
    localparam logic [tcm_pkg::IDX_W-1:0] LAST_BAD_IDX = '1;
    localparam logic [tcm_pkg::RAW_W-1:0] RAW_TOP = '1;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [tcm_pkg::REG_IDX_W-1:0] wr_index;
    logic [tcm_pkg::RES_W-1:0] wr_data;

    tcm_touch_if  touch_ch ();
    tcm_result_if res_ch ();

    touch_calibrate_and_map_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .touch    (touch_ch),
        .result   (res_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Mirror of the calibration state.
    tcm_pkg::tcm_point_t       cal_pts [tcm_pkg::NUM_POINTS];
    bit                        axes_exchanged;
    int                        gain_x;
    int                        gain_y;
    int                        touch_ctr_x;
    int                        touch_ctr_y;
    int                        screen_ctr_x;
    int                        screen_ctr_y;
    logic [tcm_pkg::RES_W-1:0] width_px;
    logic [tcm_pkg::RES_W-1:0] height_px;

    screen_report_t screen_reports_due[$];
    screen_report_t checked_report;
    int mismatches;
    int touch_items;
    int quiet_cycles;
    int result_stall;
    bit gaps_on;
    bit stalls_on;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [tcm_pkg::OUT_W-1:0] scale_axis(int gain, int raw,
                                                                    int ctr_raw, int ctr_px);
        longint prod;
        longint v;
        prod = longint'(gain) * longint'(raw - ctr_raw);
        v = prod / (longint'(1) << tcm_pkg::GAIN_FRAC_BITS) + longint'(ctr_px);
        if (v > OUT_MAX)
            v = OUT_MAX;
        if (v < OUT_MIN)
            v = OUT_MIN;
        return v[tcm_pkg::OUT_W-1:0];
    endfunction

    function automatic int span_gain(logic [tcm_pkg::RES_W-1:0] res_px, longint span);
        longint num;
        longint q;
        num = 2 * (longint'(res_px) - 2 * tcm_pkg::EDGE_MARGIN)
              * (longint'(1) << tcm_pkg::GAIN_FRAC_BITS);
        q = num / span;
        if (q > longint'(32'h7fff_ffff))
            q = longint'(32'h7fff_ffff);
        if (q < -longint'(32'h8000_0000))
            q = -longint'(32'h8000_0000);
        return int'(q);
    endfunction

    function automatic tcm_pkg::tcm_status_t run_calibration();
        int px [tcm_pkg::NUM_POINTS];
        int py [tcm_pkg::NUM_POINTS];
        int dx;
        int dy;
        int t;
        bit sw;
        longint span_x;
        longint span_y;
        for (int i = 0; i < tcm_pkg::NUM_POINTS; i++)
        begin
            px[i] = int'(cal_pts[i].x);
            py[i] = int'(cal_pts[i].y);
        end
        dx = px[tcm_pkg::POINT_B] - px[tcm_pkg::POINT_A];
        dy = py[tcm_pkg::POINT_B] - py[tcm_pkg::POINT_A];
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        sw = !(dx > dy);
        if (sw)
        begin
            for (int i = 0; i < tcm_pkg::NUM_POINTS; i++)
            begin
                t = px[i];
                px[i] = py[i];
                py[i] = t;
            end
        end
        span_x = longint'(px[tcm_pkg::POINT_B] - px[tcm_pkg::POINT_A])
                 + longint'(px[tcm_pkg::POINT_C] - px[tcm_pkg::POINT_D]);
        span_y = longint'(py[tcm_pkg::POINT_D] - py[tcm_pkg::POINT_A])
                 + longint'(py[tcm_pkg::POINT_C] - py[tcm_pkg::POINT_B]);
        if (span_x == 0 || span_y == 0)
            return tcm_pkg::STATUS_CAL_FAIL;
        axes_exchanged = sw;
        gain_x = span_gain(width_px, span_x);
        gain_y = span_gain(height_px, span_y);
        touch_ctr_x = px[tcm_pkg::POINT_E];
        touch_ctr_y = py[tcm_pkg::POINT_E];
        screen_ctr_x = int'(width_px >> 1);
        screen_ctr_y = int'(height_px >> 1);
        return tcm_pkg::STATUS_CAL_DONE;
    endfunction

    function automatic screen_report_t compute_screen_report(
        tcm_pkg::tcm_kind_t kind,
        logic [tcm_pkg::IDX_W-1:0] idx,
        logic [tcm_pkg::RAW_W-1:0] rx_in,
        logic [tcm_pkg::RAW_W-1:0] ry_in);
        screen_report_t rep;
        int rx;
        int ry;
        int t;
        rx = int'(rx_in & tcm_pkg::ADC_MASK);
        ry = int'(ry_in & tcm_pkg::ADC_MASK);
        rep.status = tcm_pkg::STATUS_STORED;
        rep.sx = '0;
        rep.sy = '0;
        if (kind == tcm_pkg::KIND_SAMPLE)
        begin
            if (axes_exchanged)
            begin
                t = rx;
                rx = ry;
                ry = t;
            end
            rep.status = tcm_pkg::STATUS_MAPPED;
            rep.sx = scale_axis(gain_x, rx, touch_ctr_x, screen_ctr_x);
            rep.sy = scale_axis(gain_y, ry, touch_ctr_y, screen_ctr_y);
        end
        else if (idx < tcm_pkg::IDX_W'(tcm_pkg::NUM_POINTS))
        begin
            cal_pts[idx].x = tcm_pkg::RAW_W'(rx);
            cal_pts[idx].y = tcm_pkg::RAW_W'(ry);
            if (idx == tcm_pkg::POINT_E)
                rep.status = run_calibration();
        end
        return rep;
    endfunction

    function automatic int idle_length();
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(12, 40));
        return int'($urandom_range(1, 3));
    endfunction

    function automatic logic [tcm_pkg::RAW_W-1:0] nudge(int v);
        int r;
        r = v + int'($urandom_range(0, 6)) - 3;
        if (r < 0)
            r = 0;
        if (r > int'(RAW_TOP))
            r = int'(RAW_TOP);
        return tcm_pkg::RAW_W'(r);
    endfunction

    task automatic send_touch(tcm_pkg::tcm_kind_t kind, logic [tcm_pkg::IDX_W-1:0] idx,
                              logic [tcm_pkg::RAW_W-1:0] rx, logic [tcm_pkg::RAW_W-1:0] ry);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 2) == 0)
            gap = idle_length();
        @(negedge clk);
        if (gap > 0)
        begin
            touch_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        touch_ch.valid = 1'b1;
        touch_ch.kind = kind;
        touch_ch.point_index = idx;
        touch_ch.raw_x = rx;
        touch_ch.raw_y = ry;
        do
            @(posedge clk);
        while (!touch_ch.ready);
        screen_reports_due.push_back(compute_screen_report(kind, idx, rx, ry));
        touch_items++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        touch_ch.valid = 1'b0;
        while (screen_reports_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_screen_size(logic [tcm_pkg::RES_W-1:0] w, logic [tcm_pkg::RES_W-1:0] h);
        @(negedge clk);
        wr_en = 1'b1;
        wr_index = tcm_pkg::REG_SCREEN_WIDTH;
        wr_data = w;
        @(negedge clk);
        wr_index = tcm_pkg::REG_SCREEN_HEIGHT;
        wr_data = h;
        @(negedge clk);
        wr_en = 1'b0;
        width_px = w;
        height_px = h;
    endtask

    task automatic send_layout(int xa, int ya, int xb, int yb, int xc, int yc, int xd, int yd,
                               int xe, int ye);
        send_touch(tcm_pkg::KIND_POINT, tcm_pkg::POINT_A, tcm_pkg::RAW_W'(xa),
                   tcm_pkg::RAW_W'(ya));
        send_touch(tcm_pkg::KIND_POINT, tcm_pkg::POINT_B, tcm_pkg::RAW_W'(xb),
                   tcm_pkg::RAW_W'(yb));
        send_touch(tcm_pkg::KIND_POINT, tcm_pkg::POINT_C, tcm_pkg::RAW_W'(xc),
                   tcm_pkg::RAW_W'(yc));
        send_touch(tcm_pkg::KIND_POINT, tcm_pkg::POINT_D, tcm_pkg::RAW_W'(xd),
                   tcm_pkg::RAW_W'(yd));
        send_touch(tcm_pkg::KIND_POINT, tcm_pkg::POINT_E, tcm_pkg::RAW_W'(xe),
                   tcm_pkg::RAW_W'(ye));
    endtask

    task automatic test_uncalibrated_samples();
        send_touch(tcm_pkg::KIND_SAMPLE, LAST_BAD_IDX, '0, '0);
        send_touch(tcm_pkg::KIND_SAMPLE, tcm_pkg::POINT_A, RAW_TOP, RAW_TOP);
        send_touch(tcm_pkg::KIND_SAMPLE, FIRST_BAD_IDX, 10'h2aa, 10'h155);
    endtask

    task automatic test_bad_point_index();
        send_touch(tcm_pkg::KIND_POINT, FIRST_BAD_IDX, RAW_TOP, '0);
        send_touch(tcm_pkg::KIND_POINT, LAST_BAD_IDX, '0, RAW_TOP);
    endtask

    task automatic test_basic_calibration();
        send_layout(100, 80, 900, 90, 910, 900, 95, 910, 505, 495);
        send_touch(tcm_pkg::KIND_SAMPLE, tcm_pkg::POINT_E, 10'd100, 10'd80);
        send_touch(tcm_pkg::KIND_SAMPLE, tcm_pkg::POINT_B, RAW_TOP, '0);
    endtask

    task automatic test_swapped_mirrored_calibration();
        send_layout(80, 900, 85, 100, 920, 95, 915, 905, 500, 500);
        send_touch(tcm_pkg::KIND_SAMPLE, tcm_pkg::POINT_C, '0, RAW_TOP);
    endtask

    task automatic test_saturation_and_zero_span();
        send_layout(500, 100, 501, 100, 501, 900, 500, 900, 500, 500);
        send_touch(tcm_pkg::KIND_SAMPLE, tcm_pkg::POINT_A, '0, '0);
        send_touch(tcm_pkg::KIND_SAMPLE, tcm_pkg::POINT_A, RAW_TOP, RAW_TOP);
        send_touch(tcm_pkg::KIND_POINT, tcm_pkg::POINT_B, 10'd499, 10'd100);
        send_touch(tcm_pkg::KIND_POINT, tcm_pkg::POINT_E, 10'd500, 10'd500);
        send_touch(tcm_pkg::KIND_SAMPLE, tcm_pkg::POINT_D, RAW_TOP, 10'd512);
    endtask

    task automatic random_calibration_sequence();
        int xl;
        int xh;
        int yl;
        int yh;
        int t;
        int px [tcm_pkg::NUM_POINTS];
        int py [tcm_pkg::NUM_POINTS];
        bit exchange;
        logic [tcm_pkg::RAW_W-1:0] a;
        logic [tcm_pkg::RAW_W-1:0] b;
        xl = int'($urandom_range(0, 300));
        xh = int'($urandom_range(700, 1023));
        yl = int'($urandom_range(0, 300));
        yh = int'($urandom_range(700, 1023));
        if ($urandom_range(0, 7) == 0)
            xh = xl + int'($urandom_range(0, 2));
        if ($urandom_range(0, 7) == 0)
            yh = yl + int'($urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0)
        begin
            t = xl;
            xl = xh;
            xh = t;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            t = yl;
            yl = yh;
            yh = t;
        end
        exchange = $urandom_range(0, 2) == 0;
        px = '{xl, xh, xh, xl, (xl + xh) / 2};
        py = '{yl, yl, yh, yh, (yl + yh) / 2};
        for (int i = 0; i < tcm_pkg::NUM_POINTS; i++)
        begin
            a = nudge(px[i]);
            b = nudge(py[i]);
            if (exchange)
                send_touch(tcm_pkg::KIND_POINT, tcm_pkg::IDX_W'(i), b, a);
            else
                send_touch(tcm_pkg::KIND_POINT, tcm_pkg::IDX_W'(i), a, b);
        end
        repeat ($urandom_range(2, 14))
            send_touch(tcm_pkg::KIND_SAMPLE, tcm_pkg::IDX_W'($urandom_range(0, 7)),
                       tcm_pkg::RAW_W'($urandom), tcm_pkg::RAW_W'($urandom));
    endtask

    task automatic run_random_phase(int n_items);
        int target;
        target = touch_items + n_items;
        while (touch_items < target)
        begin
            if ($urandom_range(0, 9) == 0)
                gaps_on = !gaps_on;
            if ($urandom_range(0, 9) == 0)
                stalls_on = !stalls_on;
            if ($urandom_range(0, 9) < 7)
                random_calibration_sequence();
            else
                repeat ($urandom_range(1, 5))
                    send_touch(tcm_pkg::tcm_kind_t'($urandom_range(0, 1)),
                               tcm_pkg::IDX_W'($urandom_range(0, 7)),
                               tcm_pkg::RAW_W'($urandom), tcm_pkg::RAW_W'($urandom));
            if ($urandom_range(0, 24) == 0)
                wait_drained();
        end
    endtask

    task automatic test_random_traffic();
        logic [tcm_pkg::RES_W-1:0] widths [6];
        logic [tcm_pkg::RES_W-1:0] heights [6];
        widths = '{12'd128, 12'd4095, 12'd4095, 12'd60,
                   tcm_pkg::RES_W'($urandom_range(128, 4095)), tcm_pkg::WIDTH_RESET};
        heights = '{12'd4095, 12'd128, 12'd4095, 12'd100,
                    tcm_pkg::RES_W'($urandom_range(128, 4095)), tcm_pkg::HEIGHT_RESET};
        for (int i = 0; i < 6; i++)
        begin
            wait_drained();
            set_screen_size(widths[i], heights[i]);
            gaps_on = i != 2;
            stalls_on = i != 2;
            run_random_phase(ITEMS_PER_PHASE);
        end
    endtask

    always @(negedge clk)
    begin
        if (result_stall > 0)
        begin
            res_ch.ready = 1'b0;
            result_stall--;
        end
        else
        begin
            res_ch.ready = 1'b1;
            if (stalls_on && $urandom_range(0, 3) == 0)
                result_stall = idle_length();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (screen_reports_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: status %0d x %0d y %0d",
                             res_ch.status, res_ch.screen_x, res_ch.screen_y);
            end
            else
            begin
                checked_report = screen_reports_due.pop_front();
                if (res_ch.status !== checked_report.status
                    || res_ch.screen_x !== checked_report.sx
                    || res_ch.screen_y !== checked_report.sy)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: status exp %0d got %0d, ",
                                  "x exp %0d got %0d, y exp %0d got %0d"},
                                 checked_report.status, res_ch.status,
                                 checked_report.sx, res_ch.screen_x,
                                 checked_report.sy, res_ch.screen_y);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((touch_ch.valid && touch_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles = quiet_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = tcm_pkg::REG_SCREEN_WIDTH;
        wr_data = '0;
        touch_ch.valid = 1'b0;
        touch_ch.kind = tcm_pkg::KIND_POINT;
        touch_ch.point_index = tcm_pkg::POINT_A;
        touch_ch.raw_x = '0;
        touch_ch.raw_y = '0;
        res_ch.ready = 1'b0;
        result_stall = 0;
        mismatches = 0;
        touch_items = 0;
        quiet_cycles = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        for (int i = 0; i < tcm_pkg::NUM_POINTS; i++)
            cal_pts[i] = '0;
        axes_exchanged = 1'b0;
        gain_x = int'(tcm_pkg::GAIN_ONE);
        gain_y = int'(tcm_pkg::GAIN_ONE);
        touch_ctr_x = 0;
        touch_ctr_y = 0;
        screen_ctr_x = 0;
        screen_ctr_y = 0;
        width_px = tcm_pkg::WIDTH_RESET;
        height_px = tcm_pkg::HEIGHT_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_uncalibrated_samples();
        test_bad_point_index();
        test_basic_calibration();
        test_swapped_mirrored_calibration();
        test_saturation_and_zero_span();
        test_random_traffic();

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
